[sv/ata_pio_lba48_read_sequencer_top_macros.svh]
// assertion macros shared by the sequencer rtl
`ifndef ATA_PIO_LBA48_READ_SEQUENCER_TOP_MACROS_SVH
`define ATA_PIO_LBA48_READ_SEQUENCER_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define APLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define APLS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/apls_pkg.sv]
// types, constants and codes of the lba48 pio read sequencer
`timescale 1ns / 1ps

package apls_pkg;

    // transfer geometry
    localparam int WORDS_PER_SECTOR  = 256;
    localparam int MAX_SECTORS       = 65535;
    localparam int BYTES_PER_SECTOR  = WORDS_PER_SECTOR * 2;
    localparam int WIS_W             = $clog2(WORDS_PER_SECTOR);
    localparam int MAX_RESULTS       = 11;
    localparam int SEQ_W             = $clog2(MAX_RESULTS);
    localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(MAX_RESULTS - 1);

    // field widths
    localparam int OP_W    = 2;
    localparam int LBA_W   = 64;
    localparam int CNT_W   = 32;
    localparam int BLEN_W  = 32;
    localparam int RVAL_W  = 16;
    localparam int PORT_W  = 9;
    localparam int WVAL_W  = 8;
    localparam int WIDX_W  = 24;
    localparam int WORD_W  = 16;
    localparam int SEC_W   = 16;
    localparam int POLL_W  = 20;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = POLL_W'(1000000);

    // port addresses
    localparam logic [PORT_W-1:0] PORT_DATA  = 9'h1F0;
    localparam logic [PORT_W-1:0] PORT_COUNT = 9'h1F2;
    localparam logic [PORT_W-1:0] PORT_LOW   = 9'h1F3;
    localparam logic [PORT_W-1:0] PORT_MID   = 9'h1F4;
    localparam logic [PORT_W-1:0] PORT_HIGH  = 9'h1F5;
    localparam logic [PORT_W-1:0] PORT_DRIVE = 9'h1F6;
    localparam logic [PORT_W-1:0] PORT_CMD   = 9'h1F7;

    // taskfile bytes and status bits
    localparam logic [WVAL_W-1:0] DRIVE_LBA_MASTER = 8'h40;
    localparam logic [WVAL_W-1:0] CMD_READ_EXT     = 8'h24;
    localparam logic [7:0]        ST_BSY           = 8'h80;
    localparam logic [7:0]        ST_DRQ           = 8'h08;
    localparam logic [7:0]        ST_DF            = 8'h20;
    localparam logic [7:0]        ST_ERR           = 8'h01;

    typedef enum logic [OP_W-1:0] {
        OP_REQ    = 2'd0,
        OP_STATUS = 2'd1,
        OP_DATA   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_POLL = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        K_WRITE = 3'd0,
        K_BREAD = 3'd1,
        K_WREAD = 3'd2,
        K_STORE = 3'd3,
        K_DONE  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNSUP     = 3'd1,
        ST_SMALL_BUF = 3'd2,
        ST_DEV_ERR   = 3'd3,
        ST_TIMEOUT   = 3'd4
    } t_status;

    typedef struct packed {
        t_phase              phase;
        logic [SEC_W-1:0]    sectors_total;
        logic [SEC_W-1:0]    sector_index;
        logic [WIS_W-1:0]    word_in_sector;
        logic [POLL_W-1:0]   poll_count;
        logic [WIDX_W-1:0]   dest_index;
    } t_seq_state;

    typedef struct packed {
        t_kind               kind;
        logic [PORT_W-1:0]   port;
        logic [WVAL_W-1:0]   write_value;
        logic [WIDX_W-1:0]   word_index;
        logic [WORD_W-1:0]   word_value;
        t_status             result_status;
        logic                last;
    } t_result;

    typedef struct packed {
        t_op                 op;
        logic [LBA_W-1:0]    lba;
        logic [CNT_W-1:0]    sector_count;
        logic [BLEN_W-1:0]   buffer_len;
        logic [RVAL_W-1:0]   read_value;
    } t_item;

endpackage

[sv/apls_step.sv]
// per-result decode: one result of the held item and the state after it
`timescale 1ns / 1ps

module apls_step
    import apls_pkg::*;
(
    input  t_item              i_item,
    input  logic [SEQ_W-1:0]   i_seq,
    input  t_seq_state         i_state,
    input  logic [POLL_W-1:0]  i_poll_limit,
    output t_result            o_result,
    output logic               o_none,
    output t_seq_state         o_next
);

    logic [7:0]             stat;
    logic [POLL_W-1:0]      limit;
    logic                   cnt_bad;
    logic                   lba_bad;
    logic [CNT_W:0]         need_bytes;
    logic                   buf_small;
    logic [SEC_W-1:0]       cnt16;
    logic                   end_sector;
    logic [SEC_W-1:0]       sec_inc;

    // request checks and status decode
    always_comb begin
        stat       = i_item.read_value[7:0];
        limit      = (i_poll_limit == '0) ? POLL_W'(1) : i_poll_limit;
        cnt_bad    = (i_item.sector_count == '0) ||
                     (i_item.sector_count > CNT_W'(MAX_SECTORS));
        lba_bad    = |i_item.lba[LBA_W-1:48];
        cnt16      = i_item.sector_count[SEC_W-1:0];
        need_bytes = (CNT_W+1)'(cnt16) * (CNT_W+1)'(BYTES_PER_SECTOR);
        buf_small  = {1'b0, i_item.buffer_len} < need_bytes;
        end_sector = (i_state.word_in_sector == WIS_W'(WORDS_PER_SECTOR - 1));
        sec_inc    = i_state.sector_index + SEC_W'(1);
    end

    // result select and next state
    always_comb begin
        o_result               = '0;
        o_result.kind          = K_WRITE;
        o_result.result_status = ST_OK;
        o_none                 = 1'b0;
        o_next                 = i_state;
        unique case (i_item.op)
            OP_REQ: begin
                if (i_state.phase != PH_IDLE) begin
                    o_none = 1'b1;
                end else if (cnt_bad || lba_bad || buf_small) begin
                    o_result.kind          = K_DONE;
                    o_result.result_status = buf_small && !cnt_bad && !lba_bad ?
                                             ST_SMALL_BUF : ST_UNSUP;
                    o_result.last          = 1'b1;
                end else begin
                    o_result.kind = K_WRITE;
                    case (i_seq)
                        4'd0: begin
                            o_result.port        = PORT_DRIVE;
                            o_result.write_value = DRIVE_LBA_MASTER;
                        end
                        4'd1: begin
                            o_result.port        = PORT_COUNT;
                            o_result.write_value = cnt16[15:8];
                        end
                        4'd2: begin
                            o_result.port        = PORT_LOW;
                            o_result.write_value = i_item.lba[31:24];
                        end
                        4'd3: begin
                            o_result.port        = PORT_MID;
                            o_result.write_value = i_item.lba[39:32];
                        end
                        4'd4: begin
                            o_result.port        = PORT_HIGH;
                            o_result.write_value = i_item.lba[47:40];
                        end
                        4'd5: begin
                            o_result.port        = PORT_COUNT;
                            o_result.write_value = cnt16[7:0];
                        end
                        4'd6: begin
                            o_result.port        = PORT_LOW;
                            o_result.write_value = i_item.lba[7:0];
                        end
                        4'd7: begin
                            o_result.port        = PORT_MID;
                            o_result.write_value = i_item.lba[15:8];
                        end
                        4'd8: begin
                            o_result.port        = PORT_HIGH;
                            o_result.write_value = i_item.lba[23:16];
                        end
                        4'd9: begin
                            o_result.port        = PORT_CMD;
                            o_result.write_value = CMD_READ_EXT;
                        end
                        default: begin
                            o_result.kind = K_BREAD;
                            o_result.port = PORT_CMD;
                            o_result.last = 1'b1;
                        end
                    endcase
                    o_next.phase          = PH_POLL;
                    o_next.sectors_total  = cnt16;
                    o_next.sector_index   = '0;
                    o_next.word_in_sector = '0;
                    o_next.dest_index     = '0;
                    o_next.poll_count     = POLL_W'(1);
                end
            end
            OP_STATUS: begin
                o_result.last = 1'b1;
                if (i_state.phase != PH_POLL) begin
                    o_none = 1'b1;
                end else if ((stat & (ST_ERR | ST_DF)) != '0) begin
                    o_result.kind          = K_DONE;
                    o_result.result_status = ST_DEV_ERR;
                    o_next.phase           = PH_IDLE;
                end else if ((stat & (ST_BSY | ST_DRQ)) == ST_DRQ) begin
                    o_result.kind         = K_WREAD;
                    o_result.port         = PORT_DATA;
                    o_next.phase          = PH_DATA;
                    o_next.word_in_sector = '0;
                end else if (i_state.poll_count >= limit) begin
                    o_result.kind          = K_DONE;
                    o_result.result_status = ST_TIMEOUT;
                    o_next.phase           = PH_IDLE;
                end else begin
                    o_result.kind     = K_BREAD;
                    o_result.port     = PORT_CMD;
                    o_next.poll_count = i_state.poll_count + POLL_W'(1);
                end
            end
            OP_DATA: begin
                if (i_state.phase != PH_DATA) begin
                    o_none = 1'b1;
                end else if (i_seq == '0) begin
                    // stored word comes first
                    o_result.kind       = K_STORE;
                    o_result.word_index = i_state.dest_index;
                    o_result.word_value = i_item.read_value;
                end else begin
                    o_result.last         = 1'b1;
                    o_next.dest_index     = i_state.dest_index + WIDX_W'(1);
                    o_next.word_in_sector = end_sector ? '0 :
                                            i_state.word_in_sector + WIS_W'(1);
                    if (!end_sector) begin
                        o_result.kind = K_WREAD;
                        o_result.port = PORT_DATA;
                    end else begin
                        o_next.sector_index = sec_inc;
                        if (sec_inc >= i_state.sectors_total) begin
                            o_result.kind          = K_DONE;
                            o_result.result_status = ST_OK;
                            o_next.phase           = PH_IDLE;
                        end else begin
                            o_result.kind     = K_BREAD;
                            o_result.port     = PORT_CMD;
                            o_next.poll_count = POLL_W'(1);
                            o_next.phase      = PH_POLL;
                        end
                    end
                end
            end
            OP_NONE: begin
                o_none = 1'b1;
            end
        endcase
    end

endmodule

[sv/apls_out_reg.sv]
// output result register with valid/ready handshake
`timescale 1ns / 1ps

module apls_out_reg
    import apls_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_result             i_result,
    input  logic                i_ready,
    output logic                o_free,
    output logic                o_valid,
    output logic [2:0]          o_kind,
    output logic [PORT_W-1:0]   o_port,
    output logic [WVAL_W-1:0]   o_write_value,
    output logic [WIDX_W-1:0]   o_word_index,
    output logic [WORD_W-1:0]   o_word_value,
    output logic [2:0]          o_result_status,
    output logic                o_last
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_result.kind;
    assign o_port          = r_result.port;
    assign o_write_value   = r_result.write_value;
    assign o_word_index    = r_result.word_index;
    assign o_word_value    = r_result.word_value;
    assign o_result_status = r_result.result_status;
    assign o_last          = r_result.last;

endmodule

[sv/ata_pio_lba48_read_sequencer_top.sv]
// Host sequencer for an ATA PIO READ SECTORS EXT transfer with 48-bit LBA.
// Each accepted item is held in an input register and its results leave one
// per clock through an output register. A status item gives one result; a
// data item gives the stored word and then the next access; a valid request
// gives eleven results (ten taskfile writes and the first status read), a
// rejected request one. Items ignored in the current phase are dropped with
// no result. The rate is set by the single result register: one result
// leaves per cycle, and a receiver that holds off stalls the input. poll_limit
// is taken on every cfg write; change it only while no transfer is running.
`timescale 1ns / 1ps

`include "ata_pio_lba48_read_sequencer_top_macros.svh"

module ata_pio_lba48_read_sequencer_top
    import apls_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [LBA_W-1:0]    i_lba,
    input  logic [CNT_W-1:0]    i_sector_count,
    input  logic [BLEN_W-1:0]   i_buffer_len,
    input  logic [RVAL_W-1:0]   i_read_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_kind,
    output logic [PORT_W-1:0]   o_port,
    output logic [WVAL_W-1:0]   o_write_value,
    output logic [WIDX_W-1:0]   o_word_index,
    output logic [WORD_W-1:0]   o_word_value,
    output logic [2:0]          o_result_status,
    output logic                o_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [POLL_W-1:0]   i_cfg_poll_limit
);

    logic               r_in_valid;
    t_item              r_item;
    logic [SEQ_W-1:0]   r_seq;
    logic [SEQ_W-1:0]   n_seq;
    t_seq_state         r_state;
    logic [POLL_W-1:0]  r_poll_limit;

    t_result            step_res;
    logic               step_none;
    t_seq_state         step_next;
    logic               out_free;
    logic               emit;
    logic               item_done;

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_poll_limit <= i_cfg_poll_limit;
        end
    end

    // handshake control
    assign emit      = r_in_valid && !step_none && out_free;
    assign item_done = r_in_valid && (step_none || (out_free && step_res.last));
    assign o_ready   = !r_in_valid || item_done;
    assign n_seq     = item_done ? '0 : (emit ? r_seq + SEQ_W'(1) : r_seq);

    // input item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (item_done) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.op           <= t_op'(i_op);
            r_item.lba          <= i_lba;
            r_item.sector_count <= i_sector_count;
            r_item.buffer_len   <= i_buffer_len;
            r_item.read_value   <= i_read_value;
        end
    end

    // result sequence counter and transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= '0;
            r_state <= '{phase: PH_IDLE, default: '0};
        end else begin
            r_seq <= n_seq;
            if (item_done) begin
                r_state <= step_next;
            end
        end
    end

    apls_step u_step (
        .i_item       (r_item),
        .i_seq        (r_seq),
        .i_state      (r_state),
        .i_poll_limit (r_poll_limit),
        .o_result     (step_res),
        .o_none       (step_none),
        .o_next       (step_next)
    );

    apls_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (emit),
        .i_result        (step_res),
        .i_ready         (i_ready),
        .o_free          (out_free),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_port          (o_port),
        .o_write_value   (o_write_value),
        .o_word_index    (o_word_index),
        .o_word_value    (o_word_value),
        .o_result_status (o_result_status),
        .o_last          (o_last)
    );

    // checks
    `APLS_ASSERT(a_seq_range, (r_seq <= SEQ_LAST), "result sequence index out of range")
    `APLS_ASSERT(a_seq_needs_item, (r_seq != '0 |-> r_in_valid), "sequence running with no item")
    `APLS_ASSERT(a_done_is_last, (o_valid && o_kind == K_DONE |-> o_last), "done result not last")
    `APLS_ASSERT(a_done_goes_idle, (emit && step_res.kind == K_DONE |=> r_state.phase == PH_IDLE), "done without return to idle")

endmodule
